[rtl/indexed_min_heap_counter_table_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the heap counter table
// Shared concurrent assertion forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_COUNTER_TABLE_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_COUNTER_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define IMHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/imhc_pkg.sv]
// ----------------------------------------------------------------------------
// imhc_pkg
// Constants, opcodes and status codes of the heap counter table.
// ----------------------------------------------------------------------------
package imhc_pkg;

	// default sizes
	localparam int ENTRIES_DEF    = 32;
	localparam int KEY_BITS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 16;

	// fixed limits
	localparam int MAX_RESULTS = 32;
	localparam int STAMP_BITS  = 32;

	// field widths on the ports
	localparam int IN_KEY_BITS    = 8;
	localparam int AMT_BITS       = 8;
	localparam int IN_DATA_BITS   = 16;
	localparam int IN_USER_BITS   = 2;
	localparam int OUT_KEY_BITS   = 8;
	localparam int OUT_COUNT_BITS = 16;
	localparam int OUT_DATA_BITS  = 24;
	localparam int OUT_USER_BITS  = 3;

	// opcodes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_SUB  = 2'd1;
	localparam logic [1:0] OP_LIST = 2'd2;
	localparam logic [1:0] OP_TRIM = 2'd3;

	// status codes
	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

[rtl/imhc_ram.sv]
// ----------------------------------------------------------------------------
// imhc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/indexed_min_heap_counter_table_core.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_counter_table_core
// Binary min-heap of keyed counters held in one RAM, ordered by count then
// by change stamp. Add, subtract, list smallest and trim smallest.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tuser       | tlast
//  s_*     | in  | key[7:0], amount[15:8]   | op[1:0]     | -
//  m_*     | out | entry_key[7:0],          | status[2:0] | last result
//          |     | entry_count[23:8]        |             |
//
//  One item at a time. A key lookup scans the occupied slots one by one, and a
//  sift walks the heap one level at a time, all through the one RAM read port.
//  List and trim scan the table once per reported entry; trim then does a
//  lookup and sift per key.
//  Reset clears the occupancy, the stamp and control; the RAM is not cleared.
//  A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_counter_table_core_macros.svh"

module indexed_min_heap_counter_table_core #(
	parameter int ENTRIES    = imhc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = imhc_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = imhc_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [imhc_pkg::IN_DATA_BITS-1:0]  s_tdata,  // key, amount
	input  logic [imhc_pkg::IN_USER_BITS-1:0]  s_tuser,  // op
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [imhc_pkg::OUT_DATA_BITS-1:0] m_tdata,  // entry_key, entry_count
	output logic [imhc_pkg::OUT_USER_BITS-1:0] m_tuser,  // status
	output logic                               m_tlast
);

	import imhc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam int LW = $clog2(MAX_RESULTS);
	localparam int SW = (COUNT_BITS > AMT_BITS) ? COUNT_BITS : AMT_BITS;
	localparam int EW = KEY_BITS + COUNT_BITS + STAMP_BITS;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_F_RD  = 14'b00000000000010,
		S_F_CK  = 14'b00000000000100,
		S_RM_RD = 14'b00000000001000,
		S_RM_CK = 14'b00000000010000,
		S_UP_RD = 14'b00000000100000,
		S_UP_CK = 14'b00000001000000,
		S_DN_RL = 14'b00000010000000,
		S_DN_RR = 14'b00000100000000,
		S_DN_CK = 14'b00001000000000,
		S_SL_RD = 14'b00010000000000,
		S_SL_CK = 14'b00100000000000,
		S_EMIT  = 14'b01000000000000,
		S_SPARE = 14'b10000000000000
	} state_t;

	// heap order: smaller count first, then older stamp
	function automatic logic before_f(input entry_t a, input entry_t b);
		if (a.count == b.count) begin
			return a.stamp < b.stamp;
		end
		return a.count < b.count;
	endfunction

	state_t                state_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [AMT_BITS-1:0]   amt_q;
	logic [OW-1:0]         occ_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [OW-1:0]         idx_q;
	logic [IW-1:0]         pos_q;
	entry_t                cur_q;
	entry_t                lft_q;
	entry_t                best_q;
	logic [IW-1:0]         best_idx_q;
	logic                  have_best_q;
	logic [ENTRIES-1:0]    taken_q;
	logic [NW-1:0]         cnt_q;
	logic [NW-1:0]         n_q;
	logic [KEY_BITS-1:0]   klist_q [MAX_RESULTS];
	logic                  up_try_q;
	logic [KEY_BITS-1:0]   res_key_q;
	logic [COUNT_BITS-1:0] res_cnt_q;
	logic [2:0]            res_st_q;
	logic                  res_last_q;
	logic                  m_valid_q;
	logic [OUT_KEY_BITS-1:0]   m_key_q;
	logic [OUT_COUNT_BITS-1:0] m_cnt_q;
	logic [2:0]            m_st_q;
	logic                  m_last_q;
	logic                  wr_en_q;
	logic [IW-1:0]         wr_addr_q;
	entry_t                wr_data_q;

	logic [IW-1:0]         ram_raddr;
	logic [EW-1:0]         ram_rdata;
	entry_t                rd_e;
	logic [KEY_BITS-1:0]   srch_key;
	logic [IW-1:0]         par_idx;
	logic [IW+1:0]         lch_w;
	logic [IW+1:0]         rch_w;
	logic                  l_ok;
	logic                  r_ok;
	logic [COUNT_BITS-1:0] add_cnt;
	logic [COUNT_BITS-1:0] sub_cnt;
	logic                  trim_last;
	logic [8:0]            amt9;
	logic [8:0]            lim9;
	logic [8:0]            neff9;
	logic                  out_free;
	logic                  dn_ml;
	logic                  dn_c2;

	imhc_ram #(
		.WIDTH(EW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en_q),
		.waddr(wr_addr_q),
		.wdata(wr_data_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// heap geometry and arithmetic on the slot just read
	assign rd_e      = entry_t'(ram_rdata);
	assign srch_key  = (op_q == OP_TRIM) ? klist_q[cnt_q[LW-1:0]] : key_q;
	assign par_idx   = IW'((pos_q - 1'b1) >> 1);
	assign lch_w     = (IW+2)'({pos_q, 1'b1});
	assign rch_w     = lch_w + 1'b1;
	assign l_ok      = lch_w < (IW+2)'(occ_q);
	assign r_ok      = rch_w < (IW+2)'(occ_q);
	assign add_cnt   = (rd_e.count == '1) ? rd_e.count : rd_e.count + 1'b1;
	assign sub_cnt   = (SW'(rd_e.count) > SW'(amt_q)) ?
		COUNT_BITS'(SW'(rd_e.count) - SW'(amt_q)) : '0;
	assign trim_last = (NW'(cnt_q + 1'b1) == n_q);
	assign out_free  = !m_valid_q || m_tready;
	assign dn_ml     = !before_f(cur_q, lft_q);
	assign dn_c2     = !before_f(dn_ml ? lft_q : cur_q, rd_e);

	// entries to report for list and trim
	assign amt9  = 9'(s_tdata[15:8]);
	assign lim9  = (9'(occ_q) < 9'(MAX_RESULTS)) ? 9'(occ_q) : 9'(MAX_RESULTS);
	assign neff9 = (amt9 < lim9) ? amt9 : lim9;

	// read address by state
	always_comb begin
		case (state_q)
			S_F_RD, S_SL_RD: ram_raddr = IW'(idx_q);
			S_RM_RD:         ram_raddr = IW'(occ_q);
			S_UP_RD:         ram_raddr = par_idx;
			S_DN_RL:         ram_raddr = IW'(lch_w);
			S_DN_RR:         ram_raddr = IW'(rch_w);
			default:         ram_raddr = '0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		wr_addr_q <= pos_q;
		wr_data_q <= cur_q;
		case (state_q)
			S_IDLE: begin
				op_q  <= s_tuser;
				key_q <= KEY_BITS'(s_tdata[7:0]);
				amt_q <= s_tdata[15:8];
				n_q   <= NW'(neff9);
				res_key_q <= '0;
				res_cnt_q <= '0;
				res_st_q  <= ST_NOTFOUND;
			end
			S_F_RD: begin
				res_key_q <= srch_key;
				res_cnt_q <= '0;
				if (op_q == OP_ADD && occ_q == OW'(ENTRIES)) begin
					res_st_q <= ST_FULL;
				end else if (op_q == OP_ADD) begin
					cur_q     <= '{key: srch_key, count: COUNT_BITS'(1), stamp: stamp_q};
					pos_q     <= IW'(occ_q);
					res_cnt_q <= COUNT_BITS'(1);
					res_st_q  <= ST_INSERTED;
				end else begin
					res_st_q <= ST_NOTFOUND;
				end
			end
			S_F_CK: begin
				res_key_q <= srch_key;
				pos_q     <= IW'(idx_q);
				if (op_q == OP_ADD) begin
					cur_q     <= '{key: srch_key, count: add_cnt, stamp: stamp_q};
					res_cnt_q <= add_cnt;
					res_st_q  <= ST_UPDATED;
				end else if (amt_q == '0) begin
					res_cnt_q <= rd_e.count;
					res_st_q  <= ST_UPDATED;
				end else begin
					cur_q     <= '{key: srch_key, count: sub_cnt, stamp: stamp_q};
					res_cnt_q <= sub_cnt;
					res_st_q  <= (sub_cnt == '0) ? ST_REMOVED : ST_UPDATED;
				end
			end
			S_RM_CK: cur_q <= rd_e;
			// parent moves down only when the moving entry goes above it
			S_UP_CK: begin
				if (before_f(cur_q, rd_e)) begin
					wr_data_q <= rd_e;
					pos_q     <= par_idx;
				end
			end
			// lone left child moves up only when it wins
			S_DN_RR: begin
				lft_q <= rd_e;
				if (!r_ok && !before_f(cur_q, rd_e)) begin
					wr_data_q <= rd_e;
					pos_q     <= IW'(lch_w);
				end
			end
			S_DN_CK: begin
				if (dn_c2) begin
					wr_data_q <= rd_e;
					pos_q     <= IW'(rch_w);
				end else if (dn_ml) begin
					wr_data_q <= lft_q;
					pos_q     <= IW'(lch_w);
				end
			end
			S_SL_RD: begin
				if (idx_q >= occ_q) begin
					klist_q[cnt_q[LW-1:0]] <= best_q.key;
					res_key_q <= best_q.key;
					res_cnt_q <= best_q.count;
					res_st_q  <= ST_UPDATED;
				end
			end
			S_SL_CK: begin
				if (!have_best_q || before_f(rd_e, best_q)) begin
					best_q     <= rd_e;
					best_idx_q <= IW'(idx_q);
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_EMIT && out_free) begin
			m_key_q  <= OUT_KEY_BITS'(res_key_q);
			m_cnt_q  <= OUT_COUNT_BITS'(res_cnt_q);
			m_st_q   <= res_st_q;
			m_last_q <= res_last_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			stamp_q     <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			have_best_q <= 1'b0;
			taken_q     <= '0;
			up_try_q    <= 1'b0;
			res_last_q  <= 1'b0;
			m_valid_q   <= 1'b0;
			wr_en_q     <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						idx_q       <= '0;
						cnt_q       <= '0;
						taken_q     <= '0;
						have_best_q <= 1'b0;
						up_try_q    <= 1'b0;
						res_last_q  <= 1'b1;
						if (s_tuser == OP_ADD || s_tuser == OP_SUB) begin
							state_q <= S_F_RD;
						end else if (neff9 == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SL_RD;
						end
					end
				end
				// key lookup
				S_F_RD: begin
					if (idx_q >= occ_q) begin
						res_last_q <= (op_q != OP_TRIM) || trim_last;
						if (op_q == OP_ADD && occ_q != OW'(ENTRIES)) begin
							occ_q    <= occ_q + 1'b1;
							stamp_q  <= stamp_q + 1'b1;
							up_try_q <= 1'b0;
							state_q  <= S_UP_RD;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_F_CK;
					end
				end
				S_F_CK: begin
					if (rd_e.key != srch_key) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_F_RD;
					end else begin
						res_last_q <= (op_q != OP_TRIM) || trim_last;
						if (op_q == OP_ADD) begin
							stamp_q <= stamp_q + 1'b1;
							state_q <= S_DN_RL;
						end else if (amt_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							stamp_q <= stamp_q + 1'b1;
							if (sub_cnt != '0) begin
								up_try_q <= 1'b0;
								state_q  <= S_UP_RD;
							end else begin
								occ_q <= occ_q - 1'b1;
								if (idx_q == occ_q - 1'b1) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_RM_RD;
								end
							end
						end
					end
				end
				// removal: last slot moves into the hole
				S_RM_RD: state_q <= S_RM_CK;
				S_RM_CK: begin
					if (pos_q == '0) begin
						state_q <= S_DN_RL;
					end else begin
						up_try_q <= 1'b1;
						state_q  <= S_UP_RD;
					end
				end
				// sift toward the root
				S_UP_RD: begin
					if (pos_q == '0) begin
						if (up_try_q) begin
							up_try_q <= 1'b0;
							state_q  <= S_DN_RL;
						end else begin
							wr_en_q <= 1'b1;
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_UP_CK;
					end
				end
				S_UP_CK: begin
					if (before_f(cur_q, rd_e)) begin
						wr_en_q  <= 1'b1;
						up_try_q <= 1'b0;
						state_q  <= S_UP_RD;
					end else if (up_try_q) begin
						up_try_q <= 1'b0;
						state_q  <= S_DN_RL;
					end else begin
						wr_en_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				// sift toward the leaves
				S_DN_RL: begin
					if (!l_ok) begin
						wr_en_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DN_RR;
					end
				end
				S_DN_RR: begin
					if (r_ok) begin
						state_q <= S_DN_CK;
					end else if (!before_f(cur_q, rd_e)) begin
						wr_en_q <= 1'b1;
						state_q <= S_DN_RL;
					end else begin
						wr_en_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_DN_CK: begin
					wr_en_q <= 1'b1;
					if (dn_c2 || dn_ml) begin
						state_q <= S_DN_RL;
					end else begin
						state_q <= S_EMIT;
					end
				end
				// selection scan for list and trim
				S_SL_RD: begin
					if (idx_q >= occ_q) begin
						taken_q[best_idx_q] <= 1'b1;
						idx_q       <= '0;
						have_best_q <= 1'b0;
						if (op_q == OP_LIST) begin
							res_last_q <= trim_last;
							cnt_q      <= cnt_q + 1'b1;
							state_q    <= S_EMIT;
						end else if (trim_last) begin
							cnt_q   <= '0;
							state_q <= S_F_RD;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (taken_q[IW'(idx_q)]) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_SL_CK;
					end
				end
				S_SL_CK: begin
					have_best_q <= 1'b1;
					idx_q       <= idx_q + 1'b1;
					state_q     <= S_SL_RD;
				end
				// hand a result to the output register
				S_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						idx_q     <= '0;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else if (op_q == OP_LIST) begin
							state_q <= S_SL_RD;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_F_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_cnt_q, m_key_q};
	assign m_tuser  = m_st_q;
	assign m_tlast  = m_last_q;

	`IMHC_ASSERT_NOW(a_occ_max, 1'b1, occ_q <= OW'(ENTRIES), "occupancy above table size")
	`IMHC_ASSERT_NOW(a_wr_range, wr_en_q, OW'(wr_addr_q) < occ_q, "write outside occupied slots")
	`IMHC_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "sequencer stayed idle after accept")
	`IMHC_ASSERT_NEXT(a_stamp_step, 1'b1, (stamp_q == $past(stamp_q)) || (stamp_q == $past(stamp_q) + 32'd1), "stamp moved by more than one")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heap counter table. A directed table covers the
// empty-table, absent-key, zero-amount, removal and extreme-field cases. A
// random stream follows that fills the table to full and keeps it busy. Every
// accepted item runs through a heap model kept in the bench. The expected
// results (the model's, or a typed row's own) are queued, and each returned
// item is checked against the oldest one. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import imhc_pkg::*;

	localparam int SLOTS     = 32;
	localparam int CNT_MAX   = 65535;
	localparam int CYC_LIMIT = 20000000;

	typedef struct packed {
		logic [7:0]  key;
		logic [15:0] count;
		logic [2:0]  status;
		logic        last;
	} heap_result_t;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  key;
		logic [7:0]  amt;
		bit          typed;
		heap_result_t res;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // key[7:0], amount[15:8]
	logic [1:0]  s_tuser = '0;  // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;       // entry_key[7:0], entry_count[23:8]
	logic [2:0]  m_tuser;       // status[2:0]
	logic        m_tlast;

	indexed_min_heap_counter_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// heap model state
	logic [7:0]  hk [SLOTS];
	logic [15:0] hc [SLOTS];
	logic [31:0] hs [SLOTS];
	int          fill;
	logic [31:0] stamp;

	heap_result_t pending[$];
	heap_result_t produced[$];
	step_row_t    steps[$];
	int           errors = 0;
	longint       cycles = 0;
	bit           quiet_out = 1'b0;

	function automatic bit precedes(int a, int b);
		if (hc[a] == hc[b])
			return hs[a] < hs[b];
		return hc[a] < hc[b];
	endfunction

	function automatic void swap_slot(int a, int b);
		logic [7:0]  k;
		logic [15:0] c;
		logic [31:0] s;
		k = hk[a]; hk[a] = hk[b]; hk[b] = k;
		c = hc[a]; hc[a] = hc[b]; hc[b] = c;
		s = hs[a]; hs[a] = hs[b]; hs[b] = s;
	endfunction

	function automatic void bubble_up(int i);
		while (i > 0 && precedes(i, (i - 1) / 2)) begin
			swap_slot(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	function automatic void bubble_down(int i);
		int l, r, m;
		forever begin
			l = 2 * i + 1;
			r = 2 * i + 2;
			m = -1;
			if (l < fill && !precedes(i, l))
				m = l;
			if (r < fill && !precedes(m < 0 ? i : m, r))
				m = (m < 0) ? r : (precedes(l, r) ? l : r);
			if (m < 0)
				return;
			swap_slot(i, m);
			i = m;
		end
	endfunction

	function automatic int slot_of(logic [7:0] key);
		for (int i = 0; i < fill; i++)
			if (hk[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void drop_slot(int i);
		fill--;
		if (i == fill)
			return;
		swap_slot(i, fill);
		if (i > 0 && precedes(i, (i - 1) / 2))
			bubble_up(i);
		else
			bubble_down(i);
	endfunction

	function automatic void note(logic [7:0] k, logic [15:0] c, logic [2:0] st);
		heap_result_t r;
		r = '{key: k, count: c, status: st, last: 1'b0};
		produced.insert(produced.size(), r);
	endfunction

	// decrement one slot, removing it at zero
	function automatic void take_from(int i, logic [7:0] amt);
		logic [7:0] k;
		k = hk[i];
		hs[i] = stamp;
		stamp++;
		hc[i] = (hc[i] > amt) ? hc[i] - amt : 16'd0;
		if (hc[i] == 0) begin
			drop_slot(i);
			note(k, 16'd0, ST_REMOVED);
		end else begin
			note(k, hc[i], ST_UPDATED);
			bubble_up(i);
		end
	endfunction

	// model one input item; results land in produced
	function automatic void heap_step(logic [1:0] op, logic [7:0] key, logic [7:0] amt);
		int i, n, got;
		bit taken [SLOTS];
		logic [7:0] picks [$];
		produced.delete();
		if (op == OP_ADD) begin
			i = slot_of(key);
			if (i < 0 && fill >= SLOTS) begin
				note(key, 16'd0, ST_FULL);
			end else if (i < 0) begin
				hk[fill] = key;
				hc[fill] = 16'd1;
				hs[fill] = stamp;
				bubble_up(fill);
				fill++;
				stamp++;
				note(key, 16'd1, ST_INSERTED);
			end else begin
				hs[i] = stamp;
				stamp++;
				if (hc[i] < CNT_MAX)
					hc[i]++;
				note(key, hc[i], ST_UPDATED);
				bubble_down(i);
			end
		end else if (op == OP_SUB) begin
			i = slot_of(key);
			if (i < 0)
				note(key, 16'd0, ST_NOTFOUND);
			else if (amt == 0)
				note(key, hc[i], ST_UPDATED);
			else
				take_from(i, amt);
		end else begin
			n = amt;
			if (n > fill) n = fill;
			if (n > MAX_RESULTS) n = MAX_RESULTS;
			foreach (taken[j]) taken[j] = 1'b0;
			for (int c = 0; c < n; c++) begin
				got = -1;
				for (int j = 0; j < fill; j++)
					if (!taken[j] && (got < 0 || precedes(j, got)))
						got = j;
				taken[got] = 1'b1;
				picks.insert(picks.size(), hk[got]);
			end
			if (picks.size() == 0)
				note(8'd0, 16'd0, ST_NOTFOUND);
			foreach (picks[c]) begin
				i = slot_of(picks[c]);
				if (i < 0)
					note(picks[c], 16'd0, ST_NOTFOUND);
				else if (op == OP_LIST)
					note(picks[c], hc[i], ST_UPDATED);
				else
					take_from(i, amt);
			end
		end
		produced[produced.size() - 1].last = 1'b1;
	endfunction

	// idle length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// present one item and record expectations at acceptance
	task automatic send(step_row_t row, bit quiet);
		int gap;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.amt, row.key};
		s_tuser  <= row.op;
		do @(posedge clk); while (!s_tready);
		heap_step(row.op, row.key, row.amt);
		if (row.typed)
			pending.insert(pending.size(), row.res);
		else
			foreach (produced[j]) pending.insert(pending.size(), produced[j]);
	endtask

	function automatic void add_row(logic [1:0] op, logic [7:0] key, logic [7:0] amt,
		bit typed = 1'b0, logic [7:0] rk = 0, logic [15:0] rc = 0, logic [2:0] rs = 0);
		step_row_t row;
		row.op = op; row.key = key; row.amt = amt; row.typed = typed;
		row.res = '{key: rk, count: rc, status: rs, last: 1'b1};
		steps.insert(steps.size(), row);
	endfunction

	// result checker
	always @(posedge clk) begin
		heap_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{key: m_tdata[7:0], count: m_tdata[23:8], status: m_tuser, last: m_tlast};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result key=%0d count=%0d status=%0d last=%0d",
					$realtime, got.key, got.count, got.status, got.last);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					$display("%0t: expected key=%0d count=%0d status=%0d last=%0d, got key=%0d count=%0d status=%0d last=%0d",
						$realtime, want.key, want.count, want.status, want.last,
						got.key, got.count, got.status, got.last);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	int stall = 0;
	always @(posedge clk) begin
		if (stall > 0) begin
			stall <= stall - 1;
			m_tready <= 1'b0;
		end else begin
			stall <= quiet_out ? 0 : idle_len();
			m_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		step_row_t row;
		int r;
		fill = 0;
		stamp = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		add_row(OP_LIST, 8'd9, 8'd5, 1, 8'd0, 16'd0, ST_NOTFOUND);
		add_row(OP_TRIM, 8'd0, 8'd255, 1, 8'd0, 16'd0, ST_NOTFOUND);
		add_row(OP_SUB, 8'd7, 8'd1, 1, 8'd7, 16'd0, ST_NOTFOUND);
		add_row(OP_ADD, 8'd0, 8'd255, 1, 8'd0, 16'd1, ST_INSERTED);
		add_row(OP_ADD, 8'd255, 8'd0, 1, 8'd255, 16'd1, ST_INSERTED);
		add_row(OP_ADD, 8'd255, 8'd0, 1, 8'd255, 16'd2, ST_UPDATED);
		add_row(OP_SUB, 8'd255, 8'd0, 1, 8'd255, 16'd2, ST_UPDATED);
		add_row(OP_LIST, 8'd0, 8'd0, 1, 8'd0, 16'd0, ST_NOTFOUND);
		add_row(OP_ADD, 8'd85, 8'd0);
		add_row(OP_ADD, 8'd170, 8'd0);
		add_row(OP_LIST, 8'd255, 8'd255);
		add_row(OP_SUB, 8'd255, 8'd255, 1, 8'd255, 16'd0, ST_REMOVED);
		add_row(OP_ADD, 8'd0, 8'd0, 1, 8'd0, 16'd2, ST_UPDATED);
		add_row(OP_SUB, 8'd85, 8'd1);
		add_row(OP_TRIM, 8'd0, 8'd1);
		add_row(OP_LIST, 8'd0, 8'd2);
		add_row(OP_TRIM, 8'd0, 8'd255);
		add_row(OP_LIST, 8'd0, 8'd1, 1, 8'd0, 16'd0, ST_NOTFOUND);
		foreach (steps[j]) send(steps[j], 1'b0);

		// random stream: add-heavy early so the table fills, mixed later
		for (int i = 0; i < 480; i++) begin
			quiet_out = (i % 150) >= 120;
			r = $urandom_range(99);
			row.typed = 1'b0;
			row.key = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(44));
			row.amt = 8'($urandom);
			if (r < ((i < 200) ? 75 : 45)) begin
				row.op = OP_ADD;
			end else if (r < 80) begin
				row.op = OP_SUB;
				if ($urandom_range(3) != 0) row.amt = 8'($urandom_range(3));
			end else if (r < 92) begin
				row.op = OP_LIST;
				if ($urandom_range(3) != 0) row.amt = 8'($urandom_range(40));
			end else begin
				row.op = OP_TRIM;
				if ($urandom_range(7) != 0) row.amt = 8'($urandom_range(3, 1));
			end
			send(row, (i % 150) >= 120);
		end
		s_tvalid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
